/* rtl/core/mandelbrot_escape_test_defines.svh */
// Assertion macros for the checker file of this block.
`ifndef MANDELBROT_ESCAPE_TEST_DEFINES_SVH
`define MANDELBROT_ESCAPE_TEST_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define MET_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mandelbrot_escape_test: port protocol violation");

// Next-cycle implication, sampled on clk and idle during reset.
`define MET_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mandelbrot_escape_test: port timing violation");

`endif

/* rtl/core/met_pkg.sv */
// ----------------------------------------------------------------------------
// met_pkg
// Shared widths, constants and types of the escape-time iteration block.
// ----------------------------------------------------------------------------
`default_nettype none
package met_pkg;
  localparam int FRAC_BITS = 27;
  localparam int C_W       = 32;
  localparam int Z_W       = 30;
  localparam int P_W       = 60;
  localparam int N_W       = 34;
  localparam int STEP_W    = 31;
  localparam int PIX_W     = 10;
  localparam int ITER_W    = 10;
  localparam logic [ITER_W-1:0] ITER_LIMIT = 10'd1023;

  localparam logic signed [N_W-1:0] BAIL_POS = 34'sd268435456;
  localparam logic signed [N_W-1:0] BAIL_NEG = -34'sd268435456;

  localparam logic [1:0] REG_LEFT  = 2'd0;
  localparam logic [1:0] REG_TOP   = 2'd1;
  localparam logic [1:0] REG_STEP  = 2'd2;
  localparam logic [1:0] REG_ITERS = 2'd3;

  typedef struct packed {
    logic signed [P_W-1:0] rr;
    logic signed [P_W-1:0] ii;
    logic signed [P_W-1:0] ri;
  } met_prod_t;
endpackage
`default_nettype wire

/* rtl/core/met_mul_cell.sv */
// ----------------------------------------------------------------------------
// met_mul_cell
// First cell of the iteration ring: forms the three products of z.
// ----------------------------------------------------------------------------
`default_nettype none
module met_mul_cell import met_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [Z_W-1:0] zr,
  input  wire logic signed [Z_W-1:0] zi,
  output met_prod_t                  prod
);
  met_prod_t prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r.rr <= P_W'(zr * zr);
      prod_r.ii <= P_W'(zi * zi);
      prod_r.ri <= P_W'(zr * zi);
    end
  end

  assign prod = prod_r;
endmodule
`default_nettype wire

/* rtl/core/met_acc_cell.sv */
// ----------------------------------------------------------------------------
// met_acc_cell
// Second cell of the iteration ring: scales, adds c, holds z and tests bailout.
// ----------------------------------------------------------------------------
`default_nettype none
module met_acc_cell import met_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  init,
  input  wire logic                  en,
  input  wire met_prod_t             prod,
  input  wire logic signed [C_W-1:0] cr,
  input  wire logic signed [C_W-1:0] ci,
  output logic signed [Z_W-1:0]      zr,
  output logic signed [Z_W-1:0]      zi,
  output logic                       escaped
);
  logic signed [P_W-1:0] diff;
  logic signed [P_W-1:0] dbl;
  logic signed [N_W-1:0] nr;
  logic signed [N_W-1:0] ni;
  logic                  esc_nxt;
  logic signed [Z_W-1:0] zr_r;
  logic signed [Z_W-1:0] zi_r;
  logic                  esc_r;

  always_comb begin
    diff = prod.rr - prod.ii;
    dbl  = prod.ri <<< 1;
    nr = {diff[P_W-1], diff[P_W-1:FRAC_BITS]} + {{(N_W-C_W){cr[C_W-1]}}, cr};
    ni = {dbl[P_W-1], dbl[P_W-1:FRAC_BITS]} + {{(N_W-C_W){ci[C_W-1]}}, ci};
    esc_nxt = (nr < BAIL_NEG) || (nr > BAIL_POS) || (ni < BAIL_NEG) || (ni > BAIL_POS);
  end

  always_ff @(posedge clk) begin
    if (init) begin
      zr_r  <= '0;
      zi_r  <= '0;
      esc_r <= 1'b0;
    end else if (en) begin
      zr_r  <= nr[Z_W-1:0];
      zi_r  <= ni[Z_W-1:0];
      esc_r <= esc_nxt;
    end
  end

  assign zr      = zr_r;
  assign zi      = zi_r;
  assign escaped = esc_r;
endmodule
`default_nettype wire

/* rtl/core/mandelbrot_escape_test.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_test
// Escape-time membership test for one pixel of a Mandelbrot view.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; it carries the pixel
// column and row. The block maps the pixel to c with the configured edges and
// step, then iterates z = z*z + c on a ring of two cells: a product cell and
// an accumulate cell, which each iteration passes through in turn.
// c is formed and registered in the setup state. The result appears on
// out_inside_set with out_valid high for one cycle. With a zero limit the
// result is given from the setup state, with no iteration run. busy stays
// high until the result is shown, and the next request can be taken in that
// same cycle. The receiver cannot stall the result. Configuration writes take
// effect at once and must be made while busy is low; the block itself does
// not enforce this. Reset returns the registers to their default view and
// drops any request in progress.
// ----------------------------------------------------------------------------
`default_nettype none
module mandelbrot_escape_test import met_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [PIX_W-1:0] in_pixel_col,
  input  wire logic [PIX_W-1:0] in_pixel_row,
  output logic                  out_valid,
  output logic                  out_inside_set,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [C_W-1:0]   cfg_data
);
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_MUL   = 2'd2;
  localparam logic [1:0] ST_ACC   = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic signed [C_W-1:0]   left_r, top_r;
  logic [STEP_W-1:0]       step_r;
  logic [ITER_W-1:0]       iters_r;
  logic [PIX_W-1:0]        col_r, row_r;
  logic signed [C_W-1:0]   cr_r, ci_r;
  logic [ITER_W-1:0]       cnt_r, cnt_nxt, limit;
  logic                    out_valid_r, out_valid_nxt;
  logic                    inside_r, inside_nxt;
  logic [STEP_W+PIX_W-1:0] pr, pi;
  logic signed [C_W+11-1:0] sr, si;
  logic signed [C_W-1:0]   cr_sat, ci_sat;
  logic                    init, mul_en, acc_en, escaped;
  logic signed [Z_W-1:0]   zr, zi;
  met_prod_t               prod;

  function automatic logic signed [C_W-1:0] sat_c(input logic signed [C_W+11-1:0] v);
    logic signed [C_W-1:0] r;
    if (v[C_W+10:C_W-1] == '0 || v[C_W+10:C_W-1] == '1) r = v[C_W-1:0];
    else if (v[C_W+10]) r = {1'b1, {(C_W-1){1'b0}}};
    else r = {1'b0, {(C_W-1){1'b1}}};
    return r;
  endfunction

  assign limit = (iters_r > ITER_LIMIT) ? ITER_LIMIT : iters_r;

  always_comb begin
    pr = STEP_W'(step_r) * (STEP_W+PIX_W)'(col_r);
    pi = STEP_W'(step_r) * (STEP_W+PIX_W)'(row_r);
    sr = {{11{left_r[C_W-1]}}, left_r} + {2'b00, pr};
    si = {{11{top_r[C_W-1]}}, top_r} + {2'b00, pi};
    cr_sat = sat_c(sr);
    ci_sat = sat_c(si);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    inside_nxt    = inside_r;
    init          = 1'b0;
    mul_en        = 1'b0;
    acc_en        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        init    = 1'b1;
        cnt_nxt = '0;
        if (limit == '0) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          inside_nxt    = 1'b1;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (escaped) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          inside_nxt    = 1'b0;
        end else if (cnt_r == limit) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          inside_nxt    = 1'b1;
        end else begin
          mul_en    = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_en    = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_MUL;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      left_r      <= -32'sd295279001;
      top_r       <= -32'sd187904819;
      step_r      <= 31'd469762;
      iters_r     <= 10'd35;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT:  left_r  <= cfg_data;
          REG_TOP:   top_r   <= cfg_data;
          REG_STEP:  step_r  <= cfg_data[STEP_W-1:0];
          REG_ITERS: iters_r <= cfg_data[ITER_W-1:0];
          default:   left_r  <= left_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    inside_r <= inside_nxt;
    if (state_r == ST_IDLE && start) begin
      col_r <= in_pixel_col;
      row_r <= in_pixel_row;
    end
    if (state_r == ST_SETUP) begin
      cr_r <= cr_sat;
      ci_r <= ci_sat;
    end
  end

  met_mul_cell u_mul (
    .clk  (clk),
    .en   (mul_en),
    .zr   (zr),
    .zi   (zi),
    .prod (prod)
  );

  met_acc_cell u_acc (
    .clk     (clk),
    .init    (init),
    .en      (acc_en),
    .prod    (prod),
    .cr      (cr_r),
    .ci      (ci_r),
    .zr      (zr),
    .zi      (zi),
    .escaped (escaped)
  );

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_inside_set = inside_r;
endmodule
`default_nettype wire

/* rtl/core/met_checker.sv */
// ----------------------------------------------------------------------------
// met_checker
// Port-level timing checks of the escape-time block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mandelbrot_escape_test_defines.svh"
module met_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);
  `MET_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `MET_ASSERT_IMP(a_result_idle, out_valid, !busy)
  `MET_ASSERT_NXT(a_result_single, out_valid, !out_valid)
  `MET_ASSERT_IMP(a_result_after_busy, out_valid, $past(busy))
endmodule

bind mandelbrot_escape_test met_checker u_met_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire

/* test/mandelbrot_escape_test_checker.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_test_checker
// Predicts the inside-set flag of each accepted pixel request and compares it
// with the block's results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_escape_test_checker import met_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire logic [PIX_W-1:0] in_pixel_col,
  input  wire logic [PIX_W-1:0] in_pixel_row,
  input  wire logic             out_valid,
  input  wire logic             out_inside_set,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [C_W-1:0]   cfg_data,
  output int                    fail_count,
  output int                    pending_count
);
  logic signed [63:0] view_left;
  logic signed [63:0] view_top;
  logic signed [63:0] view_step;
  logic [ITER_W-1:0]  view_iters;
  logic               inside_queue[$];
  int                 mismatch_count;

  function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic escape_free(input logic [PIX_W-1:0] col,
                                       input logic [PIX_W-1:0] row);
    logic signed [63:0] cr;
    logic signed [63:0] ci;
    logic signed [63:0] zr;
    logic signed [63:0] zi;
    logic signed [63:0] nr;
    logic signed [63:0] ni;
    int                 limit;
    cr = clamp_q(view_left + view_step * $signed({54'd0, col}));
    ci = clamp_q(view_top + view_step * $signed({54'd0, row}));
    zr = 0;
    zi = 0;
    limit = (view_iters > ITER_LIMIT) ? ITER_LIMIT : view_iters;
    for (int k = 0; k < limit; k++) begin
      nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
      ni = ((2 * zr * zi) >>> FRAC_BITS) + ci;
      zr = nr;
      zi = ni;
      if (zr < -64'sd268435456 || zr > 64'sd268435456 ||
          zi < -64'sd268435456 || zi > 64'sd268435456) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  assign fail_count = mismatch_count;
  assign pending_count = inside_queue.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      view_left <= -64'sd295279001;
      view_top <= -64'sd187904819;
      view_step <= 64'sd469762;
      view_iters <= 10'd35;
      inside_queue.delete();
      mismatch_count <= 0;
    end else begin
      if (out_valid) begin
        if (inside_queue.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("Unexpected result: actual inside_set=%0b", out_inside_set);
          end
        end else begin
          if (inside_queue[0] !== out_inside_set) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) begin
              $display("Mismatch: expected inside_set=%0b actual=%0b",
                       inside_queue[0], out_inside_set);
            end
          end
          void'(inside_queue.pop_front());
        end
      end
      if (start && !busy) begin
        inside_queue.push_back(escape_free(in_pixel_col, in_pixel_row));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT: view_left <= $signed(cfg_data);
          REG_TOP: view_top <= $signed(cfg_data);
          REG_STEP: view_step <= {33'd0, cfg_data[STEP_W-1:0]};
          REG_ITERS: view_iters <= cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

/* test/mandelbrot_escape_test_tb.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_test_tb
// Drives pixel requests through several views and iteration limits, with
// random idle gaps, while the checker predicts and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_escape_test_tb;
  import met_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [PIX_W-1:0] in_pixel_col;
  logic [PIX_W-1:0] in_pixel_row;
  logic             out_valid;
  logic             out_inside_set;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [C_W-1:0]   cfg_data;
  int               fail_count;
  int               pending_count;
  int               idle_pct;

  mandelbrot_escape_test i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_col(in_pixel_col), .in_pixel_row(in_pixel_row),
    .out_valid(out_valid), .out_inside_set(out_inside_set),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mandelbrot_escape_test_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_col(in_pixel_col), .in_pixel_row(in_pixel_row),
    .out_valid(out_valid), .out_inside_set(out_inside_set),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1'b1;
    in_pixel_col <= col;
    in_pixel_row <= row;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain;
    while (pending_count != 0) @(negedge clk);
    repeat (2200) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [C_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int count, input int pct);
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 7) begin
        send_pixel(10'($urandom_range(799)), 10'($urandom_range(799)));
      end else begin
        send_pixel(10'($urandom), 10'($urandom));
      end
      if (n == count / 2) begin
        drain();
      end
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_pixel_col = '0;
    in_pixel_row = '0;
    cfg_we = 1'b0;
    cfg_index = REG_LEFT;
    cfg_data = '0;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd550, 10'd400);
    send_pixel(10'd600, 10'd400);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'h155, 10'h2AA);
    drain();
    write_reg(REG_ITERS, 32'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd550, 10'd400);
    drain();
    write_reg(REG_LEFT, 32'h8000_0000);
    write_reg(REG_TOP, 32'h7FFF_FFFF);
    write_reg(REG_STEP, 32'h7FFF_FFFF);
    write_reg(REG_ITERS, 32'd1023);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    drain();
    write_reg(REG_LEFT, 32'd0);
    write_reg(REG_TOP, 32'd0);
    write_reg(REG_STEP, 32'd0);
    send_pixel(10'd5, 10'd9);
    drain();
    write_reg(REG_LEFT, 32'h0800_0000);
    write_reg(REG_TOP, 32'd0);
    send_pixel(10'd0, 10'd0);
    drain();
    write_reg(REG_LEFT, 32'($signed(-32'sd268435456)));
    write_reg(REG_TOP, 32'($signed(-32'sd268435456)));
    write_reg(REG_STEP, 32'd671088);
    write_reg(REG_ITERS, 32'd1023);
    send_pixel(10'd400, 10'd400);
    send_pixel(10'd0, 10'd400);
    drain();

    write_reg(REG_LEFT, 32'($signed(-32'sd295279001)));
    write_reg(REG_TOP, 32'($signed(-32'sd187904819)));
    write_reg(REG_STEP, 32'd469762);
    write_reg(REG_ITERS, 32'd35);
    random_phase(200, 10);
    write_reg(REG_LEFT, 32'($signed(-32'sd268435456)));
    write_reg(REG_TOP, 32'($signed(-32'sd201326592)));
    write_reg(REG_STEP, 32'd503316);
    write_reg(REG_ITERS, 32'($urandom_range(1, 120)));
    random_phase(180, 83);
    write_reg(REG_ITERS, 32'd1023);
    write_reg(REG_STEP, 32'd300000);
    random_phase(200, 0);

    if (fail_count == 0) begin
      $display("mandelbrot_escape_test_tb OK");
    end else begin
      $display("mandelbrot_escape_test_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("mandelbrot_escape_test_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
